// ===== design/rtsd_pkg.sv =====
// Shared types and constants for the significant-digit rounding block.
// Holds the sequencer state type and the decimal power tables.
// No dependencies.
package rtsd_pkg;

    localparam int POW_W      = 34;
    localparam int OUT_W      = 33;
    localparam int CNT_W      = 4;
    localparam logic [CNT_W-1:0] MAX_DIGITS = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_ADD,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Ten to the power n, for n from 0 to 10.
    function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [POW_W-1:0] p;
        case (n)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            4'd10:   p = 34'd10000000000;
            default: p = 34'd10000000000;
        endcase
        return p;
    endfunction

    // Half of ten to the power n, rounded down, for n from 0 to 10.
    function automatic logic [POW_W-1:0] half10(input logic [CNT_W-1:0] n);
        logic [POW_W-1:0] h;
        case (n)
            4'd0:    h = 34'd0;
            4'd1:    h = 34'd5;
            4'd2:    h = 34'd50;
            4'd3:    h = 34'd500;
            4'd4:    h = 34'd5000;
            4'd5:    h = 34'd50000;
            4'd6:    h = 34'd500000;
            4'd7:    h = 34'd5000000;
            4'd8:    h = 34'd50000000;
            4'd9:    h = 34'd500000000;
            4'd10:   h = 34'd5000000000;
            default: h = 34'd5000000000;
        endcase
        return h;
    endfunction

endpackage

// ===== design/round_to_significant_digits.sv =====
// Rounds an unsigned value half-up to a number of significant decimal digits.
// Depends on rtsd_pkg for the state type and the decimal power tables.
//
// Usage: drive value and digits and raise start while busy is low; the
// transaction is accepted at that clock edge and the operands are captured.
// busy stays high until the result is delivered. The result appears on
// rounded, marked by valid for one cycle; it must be taken then, since the
// receiver has no way to stall the block.
// Steps: the sequencer first counts the digits of the value, then decides on
// the rounding add. If no digits are dropped the result follows at once;
// otherwise a restoring remainder unit works through the DATA_WIDTH+1 bits
// of the sum, one bit per cycle, and a last step forms the result. A new
// transaction can be started in the cycle that valid is high. Items are
// processed one at a time.
// Reset clears the sequencer and valid; no transaction is in flight after it.
module round_to_significant_digits #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [3:0]  digits,
    output logic        valid,
    output logic [32:0] rounded
);

    localparam int SUM_W  = DATA_WIDTH + 1;
    localparam int BCNT_W = $clog2(SUM_W);
    localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(SUM_W - 1);

    rtsd_pkg::state_t state_reg, state_next;
    logic                          valid_reg, valid_next;
    logic [rtsd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rtsd_pkg::CNT_W-1:0]    keep_reg, keep_next;
    logic [DATA_WIDTH-1:0]         val_reg, val_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SUM_W-1:0]              sh_reg, sh_next;
    logic [rtsd_pkg::POW_W-1:0]    p_reg, p_next;
    logic [rtsd_pkg::POW_W-1:0]    rem_reg, rem_next;
    logic [BCNT_W-1:0]             bcnt_reg, bcnt_next;
    logic [rtsd_pkg::OUT_W-1:0]    rounded_reg, rounded_next;

    logic [rtsd_pkg::POW_W:0]      trial;
    logic [rtsd_pkg::CNT_W-1:0]    drop;

    assign busy    = (state_reg != rtsd_pkg::ST_IDLE);
    assign valid   = valid_reg;
    assign rounded = rounded_reg;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = 1'b0;
        cnt_next     = cnt_reg;
        keep_next    = keep_reg;
        val_next     = val_reg;
        sum_next     = sum_reg;
        sh_next      = sh_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        bcnt_next    = bcnt_reg;
        rounded_next = rounded_reg;
        drop         = cnt_reg - keep_reg;
        trial        = {rem_reg, sh_reg[SUM_W-1]};

        case (state_reg)
            rtsd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    val_next   = value[DATA_WIDTH-1:0];
                    keep_next  = digits;
                    cnt_next   = '0;
                    state_next = rtsd_pkg::ST_COUNT;
                end
            end
            rtsd_pkg::ST_COUNT:
            begin
                // The value has at least cnt+1 digits when it reaches 10^cnt.
                if (cnt_reg != rtsd_pkg::MAX_DIGITS &&
                    rtsd_pkg::pow10(cnt_reg) <= rtsd_pkg::POW_W'(val_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = rtsd_pkg::ST_ADD;
                end
            end
            rtsd_pkg::ST_ADD:
            begin
                if (cnt_reg <= keep_reg)
                begin
                    rounded_next = rtsd_pkg::OUT_W'(val_reg);
                    valid_next   = 1'b1;
                    state_next   = rtsd_pkg::ST_IDLE;
                end
                else
                begin
                    p_next     = rtsd_pkg::pow10(drop);
                    sum_next   = SUM_W'(val_reg) + SUM_W'(rtsd_pkg::half10(drop));
                    sh_next    = SUM_W'(val_reg) + SUM_W'(rtsd_pkg::half10(drop));
                    rem_next   = '0;
                    bcnt_next  = BCNT_LAST;
                    state_next = rtsd_pkg::ST_DIV;
                end
            end
            rtsd_pkg::ST_DIV:
            begin
                // Restoring step: bring in the next sum bit, subtract p if it fits.
                if (trial >= {1'b0, p_reg})
                begin
                    rem_next = rtsd_pkg::POW_W'(trial - {1'b0, p_reg});
                end
                else
                begin
                    rem_next = trial[rtsd_pkg::POW_W-1:0];
                end
                sh_next = {sh_reg[SUM_W-2:0], 1'b0};
                if (bcnt_reg == '0)
                begin
                    state_next = rtsd_pkg::ST_FINISH;
                end
                else
                begin
                    bcnt_next = bcnt_reg - 1'b1;
                end
            end
            rtsd_pkg::ST_FINISH:
            begin
                // Rounding down to a multiple of p is the sum less its remainder.
                rounded_next = rtsd_pkg::OUT_W'(sum_reg - rem_reg[SUM_W-1:0]);
                valid_next   = 1'b1;
                state_next   = rtsd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rtsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtsd_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            bcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg    <= keep_next;
        val_reg     <= val_next;
        sum_reg     <= sum_next;
        sh_reg      <= sh_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        rounded_reg <= rounded_next;
    end

endmodule
